/* src/tpgf_pkg.sv */
// Shared types and constants for the temperature poll and glitch filter.
package tpgf_pkg;

  // Configuration register index width and codes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_POLL_INTERVAL    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONVERSION_DELAY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPIRE           = 2'd2;

  // Reset values of the configuration registers
  localparam logic [31:0] POLL_INTERVAL_RESET    = 32'd1000;
  localparam logic [31:0] CONVERSION_DELAY_RESET = 32'd750;
  localparam logic [31:0] EXPIRE_RESET           = 32'd60000;

  // Valid reading range, sixteenths of a degree (-55 C .. 125 C)
  localparam logic signed [15:0] TEMP_MIN = -16'sd880;
  localparam logic signed [15:0] TEMP_MAX = 16'sd2000;

  // Packed widths of the stream payloads
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic [31:0] poll_interval_ms;
    logic [31:0] conversion_delay_ms;
    logic [31:0] expire_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] sensor_reading;
  } tick_t;

  typedef struct packed {
    logic               start_conversion;
    logic               reading_taken;
    logic               reading_accepted;
    logic signed [11:0] held_temp;
    logic [31:0]        held_time;
    logic               temp_fresh;
  } result_t;

endpackage

/* src/temp_poll_and_glitch_filter.sv */
// Top level of the temperature poll and glitch filter.
// A tick request accepted into the input register passes through the qualifier into
// the result register, which raises m_tvalid, once that register is free or being drained.
// Throughput: one tick per clock cycle while m_tready does not stall the output; the path
// from the input register through the qualifier into the result and state registers sets it.
// Reset (rst, synchronous): empties both registers, clears pending, held value and
// request time, and loads the configuration register reset values.
module temp_poll_and_glitch_filter (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata fields from bit 0: now_ms[31:0], sensor_reading[15:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tpgf_pkg::IN_DATA_W-1:0] s_tdata,
  // m_tdata fields from bit 0: start_conversion, reading_taken, reading_accepted,
  // held_temp[11:0], held_time[31:0], temp_fresh
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tpgf_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [tpgf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                     cfg_wdata
);
  import tpgf_pkg::*;

  cfg_t    cfg;
  tick_t   tick;
  logic    tick_valid;
  result_t result;
  result_t out_reg;
  logic    advance;

  tpgf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpgf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .step   (advance),
    .result (result)
  );

  // Move the held tick on whenever the result register is free or being drained
  assign advance  = tick_valid && (!m_tvalid || m_tready);
  assign s_tready = !tick_valid || !m_tvalid || m_tready;

  // Hold the input request
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (s_tready) begin
      tick_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      tick.now_ms         <= s_tdata[31:0];
      tick.sensor_reading <= s_tdata[47:32];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  // Pack the result, first field lowest
  assign m_tdata = {out_reg.temp_fresh, out_reg.held_time, out_reg.held_temp,
                    out_reg.reading_accepted, out_reg.reading_taken,
                    out_reg.start_conversion};

endmodule

/* src/tpgf_cfg.sv */
// Configuration register file of the temperature poll and glitch filter.
module tpgf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tpgf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                    cfg_wdata,
  output tpgf_pkg::cfg_t                 cfg
);
  import tpgf_pkg::*;

  // Write the addressed register; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_ms    <= POLL_INTERVAL_RESET;
      cfg.conversion_delay_ms <= CONVERSION_DELAY_RESET;
      cfg.expire_ms           <= EXPIRE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLL_INTERVAL:    cfg.poll_interval_ms    <= cfg_wdata;
        REG_CONVERSION_DELAY: cfg.conversion_delay_ms <= cfg_wdata;
        REG_EXPIRE:           cfg.expire_ms           <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* src/tpgf_core.sv */
// Poll scheduler, reading qualifier and held-value state.
module tpgf_core (
  input  logic              clk,
  input  logic              rst,
  input  tpgf_pkg::cfg_t    cfg,
  input  tpgf_pkg::tick_t   tick,
  input  logic              step,
  output tpgf_pkg::result_t result
);
  import tpgf_pkg::*;

  logic               pending;
  logic [31:0]        request_time;
  logic signed [11:0] stored_temp;
  logic [31:0]        stored_time;
  logic               have_value;

  logic               pending_next;
  logic [31:0]        request_time_next;
  logic signed [11:0] stored_temp_next;
  logic [31:0]        stored_time_next;
  logic               have_value_next;

  logic [31:0]        since_request;
  logic [31:0]        age_before;
  logic [31:0]        age_after;
  logic               start;
  logic               taken;
  logic               in_range;
  logic               fresh_before;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [15:0]        new_mag;
  logic               too_far;
  logic               accepted;

  // Schedule requests and qualification
  always_comb begin
    since_request = tick.now_ms - request_time;
    start = !pending && (since_request > cfg.poll_interval_ms);
    // a request made this tick restarts the elapsed time from this tick's now_ms on later ticks
    taken = pending && (since_request > cfg.conversion_delay_ms);
  end

  // Qualify the reading: range check, then glitch check against a fresh value
  always_comb begin
    in_range = (tick.sensor_reading >= TEMP_MIN) && (tick.sensor_reading <= TEMP_MAX);
    age_before = tick.now_ms - stored_time;
    fresh_before = have_value && (age_before < cfg.expire_ms);
    diff = {tick.sensor_reading[15], tick.sensor_reading}
         - {{5{stored_temp[11]}}, stored_temp};
    diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    new_mag = tick.sensor_reading[15] ? 16'(-tick.sensor_reading)
                                      : 16'(tick.sensor_reading);
    too_far = {diff_mag, 2'b00} > {3'b000, new_mag};
    accepted = taken && in_range && !(fresh_before && too_far);
  end

  // Next state
  always_comb begin
    pending_next      = start ? 1'b1 : (taken ? 1'b0 : pending);
    request_time_next = start ? tick.now_ms : request_time;
    stored_temp_next  = accepted ? tick.sensor_reading[11:0] : stored_temp;
    stored_time_next  = accepted ? tick.now_ms : stored_time;
    have_value_next   = accepted | have_value;
    age_after         = tick.now_ms - stored_time_next;
  end

  // Build the result from the updated state
  always_comb begin
    result.start_conversion = start;
    result.reading_taken    = taken;
    result.reading_accepted = accepted;
    result.held_temp        = stored_temp_next;
    result.held_time        = stored_time_next;
    result.temp_fresh       = have_value_next && (age_after < cfg.expire_ms);
  end

  // Advance state when the tick moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 1'b0;
      request_time <= '0;
      stored_temp  <= '0;
      stored_time  <= '0;
      have_value   <= 1'b0;
    end else if (step) begin
      pending      <= pending_next;
      request_time <= request_time_next;
      stored_temp  <= stored_temp_next;
      stored_time  <= stored_time_next;
      have_value   <= have_value_next;
    end
  end

endmodule

/* src/tpgf_checker.sv */
// Port-level assertions for the temperature poll and glitch filter, with bind.
module tpgf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // A stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Acceptance only follows qualification
  a_accept_taken: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("reading accepted without being taken");

  // A request and a qualification never share a tick
  a_start_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("request and qualification in one tick");

  // The held temperature stays within the valid range
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:3]) >= -12'sd880) && ($signed(m_tdata[14:3]) <= 12'sd2000))
    else $error("held temperature out of range");

endmodule

bind temp_poll_and_glitch_filter tpgf_checker u_tpgf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* bench/temp_poll_and_glitch_filter_tb.sv */
// Testbench for the temperature poll scheduler and glitch filter.
module temp_poll_and_glitch_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpgf_pkg::*;

  // Index past the last register; writes to it must leave the block unchanged
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata fields from bit 0: now_ms[31:0], sensor_reading[15:0]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata fields from bit 0: start_conversion, reading_taken, reading_accepted,
  // held_temp[11:0], held_time[31:0], temp_fresh
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]           cfg_wdata = '0;

  temp_poll_and_glitch_filter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted scheduler configuration and state
  logic [31:0] poll_ms   = POLL_INTERVAL_RESET;
  logic [31:0] delay_ms  = CONVERSION_DELAY_RESET;
  logic [31:0] expire_ms = EXPIRE_RESET;
  bit          conv_pending = 1'b0;
  logic [31:0] req_time = '0;
  int          held_val = 0;
  logic [31:0] held_at = '0;
  bit          have_held = 1'b0;

  result_t     tick_results[$];
  int          mismatch_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [31:0] ms_now = '0;

  function automatic bit held_is_fresh(input logic [31:0] t_ms);
    return have_held && ((t_ms - held_at) < expire_ms);
  endfunction

  // Advance the predicted scheduler by one tick and return its outputs
  function automatic result_t poll_and_filter(input logic [31:0] t_ms,
                                              input logic signed [15:0] rd);
    result_t r;
    bit      ok;
    int      diff;
    int      dmag;
    int      rmag;
    r = '0;
    if (((t_ms - req_time) > poll_ms) && !conv_pending) begin
      r.start_conversion = 1'b1;
      conv_pending = 1'b1;
      req_time = t_ms;
    end
    if (((t_ms - req_time) > delay_ms) && conv_pending) begin
      r.reading_taken = 1'b1;
      ok = (rd >= TEMP_MIN) && (rd <= TEMP_MAX);
      if (ok && held_is_fresh(t_ms)) begin
        diff = int'(rd) - held_val;
        dmag = (diff < 0) ? -diff : diff;
        rmag = (rd < 0) ? -int'(rd) : int'(rd);
        if (4 * dmag > rmag) ok = 1'b0;
      end
      if (ok) begin
        held_val = int'(rd);
        held_at = t_ms;
        have_held = 1'b1;
        r.reading_accepted = 1'b1;
      end
      conv_pending = 1'b0;
    end
    r.held_temp = held_val[11:0];
    r.held_time = held_at;
    r.temp_fresh = held_is_fresh(t_ms);
    return r;
  endfunction

  function automatic result_t unpack_result(input logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.start_conversion = d[0];
    r.reading_taken    = d[1];
    r.reading_accepted = d[2];
    r.held_temp        = d[14:3];
    r.held_time        = d[46:15];
    r.temp_fresh       = d[47];
    return r;
  endfunction

  // Mostly plausible readings near the held value, plus limits and noise
  function automatic logic signed [15:0] pick_reading();
    int          base;
    int          span;
    int          roll;
    logic [31:0] raw;
    roll = $urandom_range(99);
    raw = $urandom();
    if (roll < 55) begin
      base = have_held ? held_val : int'($urandom_range(2880)) - 880;
      span = ((base < 0) ? -base : base) / 4 + 2;
      return 16'(base + int'($urandom_range(2 * span)) - span);
    end
    if (roll < 75) return 16'(int'($urandom_range(2880)) - 880);
    if (roll < 88) return raw[15:0];
    if (roll < 95) begin
      case ($urandom_range(8))
        0: return TEMP_MIN;
        1: return TEMP_MIN - 16'sd1;
        2: return TEMP_MAX;
        3: return TEMP_MAX + 16'sd1;
        4: return -16'sd32768;
        5: return 16'sd32767;
        6: return -16'sd1;
        7: return 16'sd1;
        default: return 16'sd0;
      endcase
    end
    return 16'sd0;
  endfunction

  // Send one tick request, idling first at the current rate
  task automatic send_tick(input logic [31:0] t_ms, input logic signed [15:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rd, t_ms};
    do @(posedge clk); while (!s_tready);
    tick_results.push_back(poll_and_filter(t_ms, rd));
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tick_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_POLL_INTERVAL:    poll_ms = val;
      REG_CONVERSION_DELAY: delay_ms = val;
      REG_EXPIRE:           expire_ms = val;
      default: ;
    endcase
  endtask

  // Request on one tick, qualify the given reading on the next
  task automatic poll_pair(input logic [31:0] t_ms, input logic signed [15:0] rd);
    logic [31:0] raw;
    raw = $urandom();
    send_tick(t_ms, raw[15:0]);
    send_tick(t_ms + 32'd1, rd);
  endtask

  // Reset values of the registers and the strict time compares
  task automatic test_reset_values();
    send_tick(32'd0, 16'sd0);
    send_tick(32'd1000, 16'sd100);
    send_tick(32'd1001, -16'sd5);
    send_tick(32'd1751, 16'sd7);
    send_tick(32'd1752, TEMP_MAX);
    ms_now = 32'd1752;
  endtask

  // Range limits with no fresh value to compare against
  task automatic test_range_limits();
    logic signed [15:0] rd;
    int                 k;
    drain();
    write_reg(REG_POLL_INTERVAL, 32'd0);
    write_reg(REG_CONVERSION_DELAY, 32'd0);
    write_reg(REG_EXPIRE, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (k = 0; k < 6; k++) begin
      case (k)
        0: rd = -16'sd32768;
        1: rd = 16'sd32767;
        2: rd = TEMP_MIN - 16'sd1;
        3: rd = TEMP_MAX + 16'sd1;
        4: rd = TEMP_MIN;
        default: rd = TEMP_MAX;
      endcase
      ms_now += 32'd2;
      poll_pair(ms_now, rd);
    end
    ms_now += 32'd1;
  endtask

  // Zero reading against a fresh nonzero value, a stale value and a fresh zero
  task automatic test_zero_reading();
    drain();
    write_reg(REG_EXPIRE, 32'hFFFF_FFFF);
    poll_pair(ms_now + 32'd1, 16'sd0);
    // age of all ones is not younger than the largest expiry
    poll_pair(held_at - 32'd2, 16'sd0);
    ms_now = held_at + 32'd1;
    poll_pair(ms_now, 16'sd0);
    ms_now += 32'd1;
  endtask

  // Largest poll interval never requests; largest delay never qualifies
  task automatic test_config_extremes();
    drain();
    write_reg(REG_POLL_INTERVAL, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF, 16'sd0);
    drain();
    write_reg(REG_POLL_INTERVAL, 32'd0);
    write_reg(REG_CONVERSION_DELAY, 32'hFFFF_FFFF);
    send_tick(ms_now + 32'd5, 16'sd100);
    send_tick(32'd0, 16'sd100);
    ms_now = 32'd0;
  endtask

  // Random ticks under a random configuration and the given idle rates
  task automatic test_random_stream(input int n, input int idle_pct, input int stall_pct);
    int k;
    drain();
    write_reg(REG_POLL_INTERVAL, $urandom_range(600));
    write_reg(REG_CONVERSION_DELAY, $urandom_range(400));
    case ($urandom_range(9))
      0: write_reg(REG_EXPIRE, 32'd0);
      1: write_reg(REG_EXPIRE, 32'hFFFF_FFFF);
      default: write_reg(REG_EXPIRE, $urandom_range(100, 8000));
    endcase
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) ms_now = $urandom();
      else ms_now += $urandom_range(120);
      send_tick(ms_now, pick_reading());
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endtask

  // Throttle the result side at the current stall rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_result(m_tdata);
      if (tick_results.size() == 0) begin
        note_mismatch("unexpected result", '0, m_tdata[31:0]);
      end else begin
        want = tick_results.pop_front();
        if (got.start_conversion !== want.start_conversion)
          note_mismatch("start_conversion", {31'd0, want.start_conversion},
                        {31'd0, got.start_conversion});
        if (got.reading_taken !== want.reading_taken)
          note_mismatch("reading_taken", {31'd0, want.reading_taken},
                        {31'd0, got.reading_taken});
        if (got.reading_accepted !== want.reading_accepted)
          note_mismatch("reading_accepted", {31'd0, want.reading_accepted},
                        {31'd0, got.reading_accepted});
        if (got.held_temp !== want.held_temp)
          note_mismatch("held_temp", {20'd0, want.held_temp}, {20'd0, got.held_temp});
        if (got.held_time !== want.held_time)
          note_mismatch("held_time", want.held_time, got.held_time);
        if (got.temp_fresh !== want.temp_fresh)
          note_mismatch("temp_fresh", {31'd0, want.temp_fresh}, {31'd0, got.temp_fresh});
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_range_limits();
    test_zero_reading();
    test_config_extremes();
    test_random_stream(250, 0, 0);
    ms_now = 32'hFFFF_F000;
    test_random_stream(250, 67, 0);
    test_random_stream(250, 0, 67);
    test_random_stream(250, 15, 15);
    drain();
    repeat (10) @(posedge clk);
    if (tick_results.size() != 0)
      note_mismatch("missing results", '0, tick_results.size());
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
